[rtl/knn_pkg.sv]
// Shared constants, types and per-beat control records for the k-nearest-neighbor selector.
package knn_pkg;

	localparam int MAX_DIM = 16;
	localparam int K_MAX   = 16;
	localparam int MAX_POP = 1024;

	localparam int VALUE_W = 16;
	localparam int DIFF_W  = VALUE_W + 1;
	localparam int SQ_W    = 2 * VALUE_W;
	localparam int DIST_W  = 36;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = $clog2(MAX_POP + 1);
	localparam int CFG_W   = 5;
	localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIMV_W  = $clog2(MAX_DIM + 1);
	localparam int FILL_W  = $clog2(K_MAX + 1);

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DIMENSION      = 1'b1;

	// control that rides along with one coordinate beat
	typedef struct packed {
		logic             vld;
		logic             cand;
		logic             first;
		logic             ins;
		logic             last;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} knn_ctl_t;

	// answer snapshot handed to the output buffer
	typedef struct packed {
		logic                           vld;
		logic [FILL_W-1:0]              cnt;
		logic [K_MAX-1:0][IDX_W-1:0]    idx;
		logic [K_MAX-1:0][DIST_W-1:0]   dlist;
	} knn_ans_t;

endpackage

[rtl/knn_front.sv]
// Input stage: coordinate and candidate counters, target store and coordinate difference.
module knn_front import knn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     item_valid,
	input  logic                     operation,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                     last_candidate,
	input  logic [CFG_W-1:0]         dimension,
	output knn_ctl_t                 ctl_s1,
	output logic signed [DIFF_W-1:0] diff_s1
);

	logic signed [VALUE_W-1:0] tgt_q [MAX_DIM];
	logic [DIM_W-1:0]  coord_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              loading_q;
	logic              fresh_q;

	logic              accept;
	logic              is_tgt;
	logic              start;
	logic [DIMV_W-1:0] dim_eff;
	logic [DIM_W-1:0]  coord_eff;
	logic [DIM_W-1:0]  ce;
	logic [DIM_W:0]    inc;
	logic              wrap;
	logic              fin;
	logic              room;
	logic signed [DIFF_W-1:0] diff;
	knn_ctl_t          ctl;

	assign accept = item_valid && adv;
	assign is_tgt = !operation;
	assign start  = !loading_q;

	always_comb begin
		if (dimension == '0) begin
			dim_eff = DIMV_W'(1);
		end else if (dimension > CFG_W'(MAX_DIM)) begin
			dim_eff = DIMV_W'(MAX_DIM);
		end else begin
			dim_eff = DIMV_W'(dimension);
		end
	end

	// counter left past a shrunken dimension wraps to the first coordinate
	assign coord_eff = ({1'b0, coord_q} >= dim_eff) ? '0 : coord_q;
	assign ce        = (is_tgt ? start : loading_q) ? '0 : coord_eff;
	assign inc       = {1'b0, ce} + 1'b1;
	assign wrap      = (inc >= dim_eff);
	assign fin       = operation && (wrap || last_candidate);
	assign room      = (cnt_q < CNT_W'(MAX_POP));
	assign diff      = {value[VALUE_W-1], value} - {tgt_q[ce][VALUE_W-1], tgt_q[ce]};

	always_comb begin
		ctl        = '0;
		ctl.vld    = accept;
		ctl.cand   = operation;
		ctl.first  = loading_q || fresh_q;
		ctl.ins    = fin && room;
		ctl.last   = operation && last_candidate;
		ctl.clr    = is_tgt && start;
		ctl.idx    = cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_DIM; j++) begin
				tgt_q[j] <= '0;
			end
			coord_q   <= '0;
			cnt_q     <= '0;
			loading_q <= 1'b0;
			fresh_q   <= 1'b1;
		end else if (accept) begin
			if (is_tgt) begin
				tgt_q[ce] <= value;
				coord_q   <= wrap ? '0 : inc[DIM_W-1:0];
				loading_q <= 1'b1;
				if (start) begin
					cnt_q   <= '0;
					fresh_q <= 1'b1;
				end
			end else begin
				loading_q <= 1'b0;
				if (last_candidate) begin
					cnt_q   <= '0;
					coord_q <= '0;
					fresh_q <= 1'b1;
				end else begin
					if (fin && room) begin
						cnt_q <= cnt_q + 1'b1;
					end
					coord_q <= fin ? '0 : inc[DIM_W-1:0];
					fresh_q <= fin;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff;
		end
	end

endmodule

[rtl/knn_dist.sv]
// Square stage: magnitude of the coordinate difference, squared and registered.
module knn_dist import knn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  knn_ctl_t                 ctl_s1,
	input  logic signed [DIFF_W-1:0] diff_s1,
	output knn_ctl_t                 ctl_s2,
	output logic [SQ_W-1:0]          sq_s2
);

	logic [VALUE_W-1:0] neg;
	logic [VALUE_W-1:0] mag;

	// |diff| never exceeds 2^VALUE_W - 1, so it fits VALUE_W bits unsigned
	assign neg = VALUE_W'(-diff_s1);
	assign mag = diff_s1[DIFF_W-1] ? neg : diff_s1[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2 <= SQ_W'(mag) * SQ_W'(mag);
		end
	end

endmodule

[rtl/knn_list.sv]
// Distance accumulator and sorted best-k list with parallel insert.
module knn_list import knn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  knn_ctl_t         ctl_s2,
	input  logic [SQ_W-1:0]  sq_s2,
	input  logic [CFG_W-1:0] neighbor_count,
	output knn_ans_t         ans
);

	logic [DIST_W-1:0]              acc_q;
	logic [FILL_W-1:0]              filled_q;
	logic [K_MAX-1:0][IDX_W-1:0]    idx_q;
	logic [K_MAX-1:0][DIST_W-1:0]   dist_q;

	logic [DIST_W-1:0]              base;
	logic [DIST_W:0]                sum;
	logic [DIST_W-1:0]              cand_dist;
	logic [K_MAX-1:0]               keep;
	logic [K_MAX-1:0]               kext;
	logic [K_MAX-1:0][IDX_W-1:0]    idx_nxt;
	logic [K_MAX-1:0][DIST_W-1:0]   dist_nxt;
	logic [K_MAX-1:0][IDX_W-1:0]    idx_upd;
	logic [K_MAX-1:0][DIST_W-1:0]   dist_upd;
	logic [FILL_W-1:0]              filled_upd;
	logic [FILL_W-1:0]              k_eff;
	logic                           step;

	assign step      = adv && ctl_s2.vld;
	assign base      = ctl_s2.first ? '0 : acc_q;
	assign sum       = {1'b0, base} + (DIST_W+1)'(sq_s2);
	assign cand_dist = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

	// keep marks entries that rank ahead of the new one; ties go to the older entry
	always_comb begin
		for (int j = 0; j < K_MAX; j++) begin
			keep[j] = (FILL_W'(j) < filled_q) && !(cand_dist < dist_q[j]);
		end
		kext = {keep[K_MAX-2:0], 1'b1};
		for (int j = 0; j < K_MAX; j++) begin
			if (keep[j]) begin
				idx_nxt[j]  = idx_q[j];
				dist_nxt[j] = dist_q[j];
			end else if (kext[j]) begin
				idx_nxt[j]  = ctl_s2.idx;
				dist_nxt[j] = cand_dist;
			end else begin
				idx_nxt[j]  = idx_q[(j > 0) ? j - 1 : 0];
				dist_nxt[j] = dist_q[(j > 0) ? j - 1 : 0];
			end
		end
	end

	assign idx_upd    = ctl_s2.ins ? idx_nxt : idx_q;
	assign dist_upd   = ctl_s2.ins ? dist_nxt : dist_q;
	assign filled_upd = (ctl_s2.ins && (filled_q < FILL_W'(K_MAX))) ? filled_q + 1'b1
		: filled_q;

	always_comb begin
		if ((CFG_W + FILL_W)'(neighbor_count) > (CFG_W + FILL_W)'(K_MAX)) begin
			k_eff = FILL_W'(K_MAX);
		end else begin
			k_eff = FILL_W'(neighbor_count);
		end
	end

	always_comb begin
		ans       = '0;
		ans.vld   = step && ctl_s2.last;
		ans.cnt   = (k_eff < filled_upd) ? k_eff : filled_upd;
		ans.idx   = idx_upd;
		ans.dlist = dist_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			filled_q <= '0;
		end else if (step) begin
			if (ctl_s2.clr) begin
				filled_q <= '0;
			end
			if (ctl_s2.cand) begin
				acc_q    <= cand_dist;
				filled_q <= ctl_s2.last ? '0 : filled_upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && ctl_s2.ins) begin
			idx_q  <= idx_nxt;
			dist_q <= dist_nxt;
		end
	end

endmodule

[rtl/knn_emit.sv]
// Output buffer: holds one answer and delivers it one beat at a time.
module knn_emit import knn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  knn_ans_t          ans,
	input  logic              result_stall,
	output logic              result_valid,
	output logic [IDX_W-1:0]  neighbor_index,
	output logic [DIST_W-1:0] neighbor_distance,
	output logic              last_of_run,
	output logic              none_selected
);

	logic [K_MAX-1:0][IDX_W-1:0]  idx_q;
	logic [K_MAX-1:0][DIST_W-1:0] dist_q;
	logic [FILL_W-1:0]            rem_q;
	logic                         none_q;
	logic                         take;

	assign result_valid      = (rem_q != '0);
	assign take              = result_valid && !result_stall;
	assign last_of_run       = (rem_q == FILL_W'(1));
	assign none_selected     = none_q;
	assign neighbor_index    = none_q ? '0 : idx_q[0];
	assign neighbor_distance = none_q ? '0 : dist_q[0];

	// a load only arrives while the buffer is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			none_q <= 1'b0;
		end else if (ans.vld) begin
			rem_q  <= (ans.cnt == '0) ? FILL_W'(1) : ans.cnt;
			none_q <= (ans.cnt == '0);
		end else if (take) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ans.vld) begin
			idx_q  <= ans.idx;
			dist_q <= ans.dlist;
		end else if (take) begin
			for (int j = 0; j < K_MAX - 1; j++) begin
				idx_q[j]  <= idx_q[j + 1];
				dist_q[j] <= dist_q[j + 1];
			end
		end
	end

endmodule

[rtl/k_nearest_neighbor_select.sv]
// Top level of the brute-force k-nearest-neighbor selector.
// Accepts one coordinate beat per cycle: target coordinates first, then candidate
// coordinates; each beat passes an input stage (target lookup and difference), a
// squaring stage and the list stage, where the distance is accumulated and a finished
// candidate is inserted into the sorted best-k list against all entries at once, so an
// answer is loaded into the output buffer directly from the list stage.
// The answer then leaves one result per cycle while result_stall is low (min(k, n)
// beats, or one empty beat when k or n is zero). item_stall rises only while
// an answer sits in the list stage and the previous answer still has beats in the
// output buffer; otherwise the input sustains one beat per cycle.
module k_nearest_neighbor_select import knn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     operation,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                     last_candidate,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [IDX_W-1:0]         neighbor_index,
	output logic [DIST_W-1:0]        neighbor_distance,
	output logic                     last_of_run,
	output logic                     none_selected,
	input  logic                     write_enable,
	input  logic [REG_IDX_W-1:0]     register_index,
	input  logic [CFG_W-1:0]         write_data
);

	logic [CFG_W-1:0]         nc_q;
	logic [CFG_W-1:0]         dim_q;
	logic                     adv;
	knn_ctl_t                 ctl_s1;
	knn_ctl_t                 ctl_s2;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [SQ_W-1:0]          sq_s2;
	knn_ans_t                 ans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q  <= CFG_W'(1);
			dim_q <= CFG_W'(16);
		end else if (write_enable) begin
			case (register_index)
				REG_NEIGHBOR_COUNT: nc_q <= write_data;
				REG_DIMENSION:      dim_q <= write_data;
				default: ;
			endcase
		end
	end

	// hold the pipe while a new answer would overrun the output buffer
	assign adv        = !(ctl_s2.vld && ctl_s2.last && result_valid);
	assign item_stall = !adv;

	knn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.item_valid     (item_valid),
		.operation      (operation),
		.value          (value),
		.last_candidate (last_candidate),
		.dimension      (dim_q),
		.ctl_s1         (ctl_s1),
		.diff_s1        (diff_s1)
	);

	knn_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.diff_s1 (diff_s1),
		.ctl_s2  (ctl_s2),
		.sq_s2   (sq_s2)
	);

	knn_list u_list (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.ctl_s2         (ctl_s2),
		.sq_s2          (sq_s2),
		.neighbor_count (nc_q),
		.ans            (ans)
	);

	knn_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.ans               (ans),
		.result_stall      (result_stall),
		.result_valid      (result_valid),
		.neighbor_index    (neighbor_index),
		.neighbor_distance (neighbor_distance),
		.last_of_run       (last_of_run),
		.none_selected     (none_selected)
	);

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled while output buffer empty");

	a_empty_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none_selected |-> last_of_run)
		else $error("empty answer not marked last");

	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && last_of_run |=> !result_valid)
		else $error("new answer loaded on top of a draining one");

endmodule

[dv/tb_k_nearest_neighbor_select.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the k-nearest-neighbor selector: directed and random queries.
module tb_k_nearest_neighbor_select;
	import knn_pkg::*;

	localparam logic OP_TARGET    = 1'b0;
	localparam logic OP_CANDIDATE = 1'b1;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   RANDOM_ITEMS  = 190;
	localparam int   QUIET_TAIL    = 40;
	localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sqdist;
		logic              last;
		logic              none;
	} neighbor_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_stall;
	logic                      operation;
	logic signed [VALUE_W-1:0] value;
	logic                      last_candidate;
	logic                      result_valid;
	logic                      result_stall;
	logic [IDX_W-1:0]          neighbor_index;
	logic [DIST_W-1:0]         neighbor_distance;
	logic                      last_of_run;
	logic                      none_selected;
	logic                      write_enable;
	logic [REG_IDX_W-1:0]      register_index;
	logic [CFG_W-1:0]          write_data;

	neighbor_t pending_neighbors[$];

	// predictor state
	logic signed [VALUE_W-1:0] target_vec [MAX_DIM];
	logic [DIST_W-1:0]         dist_acc;
	int                        coord_pos;
	int                        cand_num;
	int                        ranked;
	logic [IDX_W-1:0]          rank_idx [K_MAX];
	logic [DIST_W-1:0]         rank_dist [K_MAX];
	bit                        loading_target;
	int                        k_reg;
	int                        dim_reg;

	int errors;
	int items_sent;
	bit tx_gaps;
	bit rx_gaps;

	k_nearest_neighbor_select dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.operation        (operation),
		.value            (value),
		.last_candidate   (last_candidate),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.neighbor_index   (neighbor_index),
		.neighbor_distance(neighbor_distance),
		.last_of_run      (last_of_run),
		.none_selected    (none_selected),
		.write_enable     (write_enable),
		.register_index   (register_index),
		.write_data       (write_data)
	);

	always #5 clk = ~clk;

	function automatic int active_dim();
		if (dim_reg == 0) return 1;
		if (dim_reg > MAX_DIM) return MAX_DIM;
		return dim_reg;
	endfunction

	function automatic void clear_ranking();
		ranked = 0;
		cand_num = 0;
		coord_pos = 0;
		dist_acc = '0;
	endfunction

	// sorted insert; ties keep arrival order, the tail entry drops off when full
	function automatic void rank_candidate(int idx, logic [DIST_W-1:0] d);
		int pos;
		int i;
		pos = ranked;
		while (pos > 0 && d < rank_dist[pos-1]) pos--;
		if (pos >= K_MAX) return;
		i = (ranked < K_MAX) ? ranked : K_MAX - 1;
		for (; i > pos; i--) begin
			rank_idx[i] = rank_idx[i-1];
			rank_dist[i] = rank_dist[i-1];
		end
		rank_idx[pos] = IDX_W'(idx);
		rank_dist[pos] = d;
		if (ranked < K_MAX) ranked++;
	endfunction

	function automatic void predict_beat(logic op, logic signed [VALUE_W-1:0] val, logic is_last);
		int dim;
		int k;
		int n;
		int i;
		longint diff;
		longint sum;
		neighbor_t nb;
		dim = active_dim();
		if (op == OP_TARGET) begin
			if (!loading_target) begin
				clear_ranking();
				loading_target = 1'b1;
			end
			if (coord_pos >= dim) coord_pos = 0;
			target_vec[coord_pos] = val;
			coord_pos++;
			if (coord_pos >= dim) coord_pos = 0;
			return;
		end
		if (loading_target) begin
			loading_target = 1'b0;
			coord_pos = 0;
			dist_acc = '0;
		end
		if (coord_pos >= dim) coord_pos = 0;
		diff = longint'(val) - longint'(target_vec[coord_pos]);
		if (diff < 0) diff = -diff;
		sum = longint'(dist_acc) + diff * diff;
		dist_acc = (sum > longint'(DIST_SAT)) ? DIST_SAT : DIST_W'(sum);
		coord_pos++;
		if (coord_pos >= dim || is_last) begin
			if (cand_num < MAX_POP) begin
				rank_candidate(cand_num, dist_acc);
				cand_num++;
			end
			coord_pos = 0;
			dist_acc = '0;
		end
		if (!is_last) return;
		k = (k_reg > K_MAX) ? K_MAX : k_reg;
		n = (k < ranked) ? k : ranked;
		if (n == 0) begin
			nb = '{idx: '0, sqdist: '0, last: 1'b1, none: 1'b1};
			pending_neighbors = {pending_neighbors, nb};
		end
		for (i = 0; i < n; i++) begin
			nb = '{idx: rank_idx[i], sqdist: rank_dist[i], last: (i == n - 1), none: 1'b0};
			pending_neighbors = {pending_neighbors, nb};
		end
		clear_ranking();
	endfunction

	function automatic int random_coord();
		case ($urandom_range(0, 5))
			0: case ($urandom_range(0, 3))
				0: return -32768;
				1: return 32767;
				2: return 0;
				default: return -1;
			endcase
			1, 2: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 6)) - 3;
		endcase
	endfunction

	function automatic int random_k();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return K_MAX;
			2: return $urandom_range(K_MAX + 1, 31);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int random_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return MAX_DIM;
			2: return $urandom_range(MAX_DIM + 1, 31);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic void check_field(string field, logic [DIST_W-1:0] want,
			logic [DIST_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// result beats: stable from negedge until the accepting posedge
	always @(negedge clk) begin : result_check
		neighbor_t want;
		neighbor_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = '{idx: neighbor_index, sqdist: neighbor_distance, last: last_of_run,
				none: none_selected};
			if (pending_neighbors.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual idx %0d dist %0d",
					$time, neighbor_index, neighbor_distance);
				errors++;
			end else begin
				want = pending_neighbors.pop_front();
				check_field("neighbor_index", DIST_W'(want.idx), DIST_W'(got.idx));
				check_field("neighbor_distance", want.sqdist, got.sqdist);
				check_field("last_of_run", DIST_W'(want.last), DIST_W'(got.last));
				check_field("none_selected", DIST_W'(want.none), DIST_W'(got.none));
			end
		end
	end

	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_gaps && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic op, int val, logic is_last);
		bit stalled;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		value <= VALUE_W'(val);
		last_candidate <= is_last;
		do begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end while (stalled);
		predict_beat(op, VALUE_W'(val), is_last);
		items_sent++;
	endtask

	// hold input until all answers are out, then let the pipeline settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_neighbors.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(int k, int dim);
		wait_idle();
		write_enable <= 1'b1;
		register_index <= REG_NEIGHBOR_COUNT;
		write_data <= CFG_W'(k);
		@(posedge clk);
		k_reg = k & 31;
		register_index <= REG_DIMENSION;
		write_data <= CFG_W'(dim);
		@(posedge clk);
		dim_reg = dim & 31;
		write_enable <= 1'b0;
	endtask

	// reset values k=1, dim=16, zero target; last beat closes a short candidate
	task automatic test_reset_defaults();
		send_item(OP_CANDIDATE, 3, 1'b0);
		send_item(OP_CANDIDATE, -4, 1'b0);
		send_item(OP_CANDIDATE, 12, 1'b1);
	endtask

	task automatic test_value_extremes();
		write_config(K_MAX, 2);
		send_item(OP_TARGET, -32768, 1'b0);
		send_item(OP_TARGET, 32767, 1'b0);
		send_item(OP_CANDIDATE, 32767, 1'b0);
		send_item(OP_CANDIDATE, -32768, 1'b0);
		send_item(OP_CANDIDATE, -32768, 1'b0);
		send_item(OP_CANDIDATE, 32767, 1'b1);
	endtask

	// third target coordinate wraps onto the first; last flag on a target is ignored
	task automatic test_target_wrap();
		write_config(3, 2);
		send_item(OP_TARGET, 7, 1'b1);
		send_item(OP_TARGET, 100, 1'b0);
		send_item(OP_TARGET, -50, 1'b0);
		send_item(OP_CANDIDATE, -50, 1'b0);
		send_item(OP_CANDIDATE, 90, 1'b0);
		send_item(OP_CANDIDATE, 7, 1'b0);
		send_item(OP_CANDIDATE, 100, 1'b1);
	endtask

	task automatic test_tie_order();
		write_config(K_MAX, 1);
		send_item(OP_TARGET, 0, 1'b0);
		send_item(OP_CANDIDATE, 5, 1'b0);
		send_item(OP_CANDIDATE, -5, 1'b0);
		send_item(OP_CANDIDATE, 5, 1'b0);
		send_item(OP_CANDIDATE, 0, 1'b0);
		send_item(OP_CANDIDATE, -5, 1'b1);
	endtask

	task automatic test_zero_neighbors();
		write_config(0, 1);
		send_item(OP_CANDIDATE, 9, 1'b1);
	endtask

	// k above K_MAX acts as K_MAX, dimension 0 acts as 1
	task automatic test_config_clamp();
		write_config(31, 0);
		send_item(OP_CANDIDATE, 3, 1'b0);
		send_item(OP_CANDIDATE, -2, 1'b1);
	endtask

	// a new target in the middle of a query drops it without an answer
	task automatic test_restart_mid_query();
		write_config(4, 1);
		send_item(OP_CANDIDATE, 1, 1'b0);
		send_item(OP_CANDIDATE, 2, 1'b0);
		send_item(OP_TARGET, 10, 1'b0);
		send_item(OP_CANDIDATE, 13, 1'b1);
	endtask

	task automatic test_k_raise_mid_query();
		write_config(1, 1);
		send_item(OP_CANDIDATE, 4, 1'b0);
		send_item(OP_CANDIDATE, -1, 1'b0);
		write_config(5, 1);
		send_item(OP_CANDIDATE, 2, 1'b1);
	endtask

	task automatic test_random_queries();
		int start;
		int dim;
		int n_cand;
		int len;
		int j;
		int c;
		int kind;
		bit need_target;
		bit tail;
		start = items_sent;
		write_config(K_MAX, 31);
		need_target = 1'b1;
		while (items_sent - start < RANDOM_ITEMS) begin
			tail = (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL);
			if (tail) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_gaps = $urandom_range(0, 3) != 0;
			end
			if (!tail && $urandom_range(0, 2) == 0)
				write_config(random_k(), random_dim());
			dim = active_dim();
			if (need_target || $urandom_range(0, 2) == 0) begin
				len = dim + ($urandom_range(0, 5) == 0);
				for (c = 0; c < len; c++)
					send_item(OP_TARGET, random_coord(), $urandom_range(0, 5) == 0);
				need_target = 1'b0;
			end
			// kind 0: query abandoned by the next target, kind 1: short final candidate
			kind = $urandom_range(0, 7);
			n_cand = (dim > 4) ? $urandom_range(1, 3) : $urandom_range(1, 12);
			for (j = 0; j < n_cand; j++) begin
				len = (j == n_cand - 1 && kind == 1) ? $urandom_range(1, dim) : dim;
				for (c = 0; c < len; c++)
					send_item(OP_CANDIDATE, random_coord(),
						j == n_cand - 1 && c == len - 1 && kind != 0);
			end
			if (kind == 0) need_target = 1'b1;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = OP_TARGET;
		value = '0;
		last_candidate = 1'b0;
		write_enable = 1'b0;
		register_index = REG_NEIGHBOR_COUNT;
		write_data = '0;
		errors = 0;
		items_sent = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		k_reg = 1;
		dim_reg = MAX_DIM;
		loading_target = 1'b0;
		foreach (target_vec[i]) target_vec[i] = '0;
		foreach (rank_idx[i]) begin
			rank_idx[i] = '0;
			rank_dist[i] = '0;
		end
		clear_ranking();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_value_extremes();
		test_target_wrap();
		test_tie_order();
		test_zero_neighbors();
		test_config_clamp();
		test_restart_mid_query();
		test_k_raise_mid_query();
		test_random_queries();
		wait_idle();
		if (errors == 0 && pending_neighbors.size() == 0)
			$display("k_nearest_neighbor_select regression: pass");
		else
			$display("k_nearest_neighbor_select regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("k_nearest_neighbor_select regression: fail");
		$finish;
	end

endmodule

[files.f]
rtl/knn_pkg.sv
rtl/knn_front.sv
rtl/knn_dist.sv
rtl/knn_list.sv
rtl/knn_emit.sv
rtl/k_nearest_neighbor_select.sv
dv/tb_k_nearest_neighbor_select.sv
